@@ rtl/core/pabpp_pkg.sv @@
// ----------------------------------------------------------------------------
// pabpp_pkg
// Shared types and constants of the phase-aware block prefetch policy:
// register indexes, phase and mode codes, status codes and the structs
// that travel between the policy's modules.
// ----------------------------------------------------------------------------
package pabpp_pkg;

  // Size of one block in bytes; a backward target steps down by this much
  localparam logic [63:0] BLOCK_BYTES = 64'd2097152;

  // Configuration register indexes
  localparam logic [1:0] REG_PHASE        = 2'd0;
  localparam logic [1:0] REG_DECODE_MODE  = 2'd1;
  localparam logic [1:0] REG_RADIUS_PAGES = 2'd2;
  localparam logic [1:0] REG_CROSS_BLOCK  = 2'd3;

  // Phase codes
  localparam logic [1:0] PH_UNKNOWN = 2'd0;
  localparam logic [1:0] PH_PREFILL = 2'd1;
  localparam logic [1:0] PH_DECODE  = 2'd2;

  // Decode region modes
  localparam logic [1:0] MODE_FULL    = 2'd0;
  localparam logic [1:0] MODE_RADIUS  = 2'd1;
  localparam logic [1:0] MODE_KERNEL  = 2'd2;
  localparam logic [1:0] MODE_FORWARD = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_DEFAULT    = 3'd0;
  localparam logic [2:0] ST_DECODE_NXB = 3'd1;
  localparam logic [2:0] ST_NO_CONTEXT = 3'd2;
  localparam logic [2:0] ST_SAME_BLOCK = 3'd3;
  localparam logic [2:0] ST_NO_DIR     = 3'd4;
  localparam logic [2:0] ST_ZERO_TGT   = 3'd5;
  localparam logic [2:0] ST_DUPLICATE  = 3'd6;
  localparam logic [2:0] ST_ISSUED     = 3'd7;

  localparam logic [9:0] RADIUS_RESET = 10'd32;

  // Register file contents
  typedef struct packed {
    logic [1:0] phase;
    logic [1:0] decode_mode;
    logic [9:0] radius_pages;
    logic       cross_block_in_decode;
  } cfg_t;

  // Region decision
  typedef struct packed {
    logic       handled;
    logic       region_valid;
    logic [9:0] result_lo;
    logic [9:0] result_hi;
  } region_t;

  // Cross-block decision
  typedef struct packed {
    logic [2:0]  status;
    logic        issue;
    logic [63:0] target_space;
    logic [63:0] target_addr;
  } xb_result_t;

endpackage

@@ rtl/core/pabpp_ifs.sv @@
// ----------------------------------------------------------------------------
// pabpp_ifs
// Valid/ready channels of the prefetch policy: the fault hint going in and
// the policy result coming out.
// ----------------------------------------------------------------------------
interface pabpp_hint_if ();
  logic        valid;
  logic        ready;
  logic [8:0]  fault_page;
  logic [8:0]  region_lo;
  logic [9:0]  region_hi;
  logic [63:0] blk_end;
  logic [63:0] space_tag;

  modport source (output valid, fault_page, region_lo, region_hi, blk_end, space_tag,
                  input ready);
  modport sink (input valid, fault_page, region_lo, region_hi, blk_end, space_tag,
                output ready);
endinterface

interface pabpp_result_if ();
  logic        valid;
  logic        ready;
  logic        handled;
  logic        region_valid;
  logic [9:0]  result_lo;
  logic [9:0]  result_hi;
  logic [2:0]  status;
  logic        issue;
  logic [63:0] target_space;
  logic [63:0] target_addr;

  modport source (output valid, handled, region_valid, result_lo, result_hi, status, issue,
                  target_space, target_addr, input ready);
  modport sink (input valid, handled, region_valid, result_lo, result_hi, status, issue,
                target_space, target_addr, output ready);
endinterface

@@ rtl/core/pabpp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// pabpp_cfg_regs
// Configuration register file: phase, decode mode, radius and the
// cross-block enable, written through a plain write port.
// ----------------------------------------------------------------------------
module pabpp_cfg_regs import pabpp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_wdata,
  output cfg_t       cfg
);

  // Store writes; a phase outside prefill and decode reads back as unknown
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase                 <= PH_UNKNOWN;
      cfg.decode_mode           <= MODE_FULL;
      cfg.radius_pages          <= RADIUS_RESET;
      cfg.cross_block_in_decode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE: begin
          cfg.phase <= (cfg_wdata == {8'd0, PH_PREFILL} ||
                        cfg_wdata == {8'd0, PH_DECODE}) ? cfg_wdata[1:0] : PH_UNKNOWN;
        end
        REG_DECODE_MODE:  cfg.decode_mode           <= cfg_wdata[1:0];
        REG_RADIUS_PAGES: cfg.radius_pages          <= cfg_wdata;
        REG_CROSS_BLOCK:  cfg.cross_block_in_decode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/pabpp_region.sv @@
// ----------------------------------------------------------------------------
// pabpp_region
// Page region choice: whole region in prefill, otherwise by decode mode
// (full, radius clamped to the region, forward to the end, or defer).
// ----------------------------------------------------------------------------
module pabpp_region import pabpp_pkg::*; (
  input  cfg_t       cfg,
  input  logic [8:0] fault_page,
  input  logic [8:0] region_lo,
  input  logic [9:0] region_hi,
  output region_t    region
);

  logic [9:0]  page_w;
  logic [9:0]  lo_w;
  logic [9:0]  rad_lo;
  logic [10:0] rad_hi;

  assign page_w = {1'b0, fault_page};
  assign lo_w   = {1'b0, region_lo};

  // Radius window, clamped to the allowed region
  always_comb begin
    rad_lo = (page_w > cfg.radius_pages) ? page_w - cfg.radius_pages : lo_w;
    if (rad_lo < lo_w) begin
      rad_lo = lo_w;
    end
    rad_hi = {2'b00, fault_page} + {1'b0, cfg.radius_pages};
    if (rad_hi > {1'b0, region_hi}) begin
      rad_hi = {1'b0, region_hi};
    end
  end

  // Select the region by phase and mode
  always_comb begin
    region.handled      = 1'b1;
    region.region_valid = 1'b1;
    region.result_lo    = lo_w;
    region.result_hi    = region_hi;
    if (cfg.phase != PH_PREFILL) begin
      case (cfg.decode_mode)
        MODE_KERNEL: begin
          region.handled      = 1'b0;
          region.region_valid = 1'b0;
          region.result_lo    = '0;
          region.result_hi    = '0;
        end
        MODE_RADIUS: begin
          region.result_lo = rad_lo;
          region.result_hi = rad_hi[9:0];
        end
        MODE_FORWARD: begin
          region.result_lo = page_w;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/pabpp_xblock.sv @@
// ----------------------------------------------------------------------------
// pabpp_xblock
// Cross-block prefetch: two-entry block-end history, direction check and
// duplicate filter. State moves only when a request leaves the input stage.
// ----------------------------------------------------------------------------
module pabpp_xblock import pabpp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  cfg_t        cfg,
  input  logic [63:0] blk_end,
  input  logic [63:0] space_tag,
  input  logic [63:0] fwd_target,
  input  logic [63:0] bwd_target,
  output xb_result_t  res
);

  logic [63:0] older_end;
  logic [63:0] newer_end;
  logic [63:0] issued_tgt;
  // Sign class of newer_end - older_end, kept so only one wide subtract runs
  logic        d1_pos;
  logic        d1_neg;

  logic [63:0] d2;
  logic        d2_pos;
  logic        d2_neg;
  logic        shift;
  logic [63:0] target;

  assign d2     = blk_end - newer_end;
  assign d2_pos = (d2 != 64'd0) && !d2[63];
  assign d2_neg = d2[63];

  // Walk the decision chain
  always_comb begin
    res    = '0;
    shift  = 1'b0;
    target = '0;
    if (cfg.phase != PH_PREFILL && cfg.decode_mode == MODE_KERNEL) begin
      res.status = ST_DEFAULT;
    end else if (cfg.phase != PH_PREFILL && !cfg.cross_block_in_decode) begin
      res.status = ST_DECODE_NXB;
    end else if (space_tag == 64'd0 || blk_end == 64'd0) begin
      res.status = ST_NO_CONTEXT;
    end else if (blk_end == newer_end) begin
      res.status = ST_SAME_BLOCK;
    end else begin
      shift = 1'b1;
      if (older_end == 64'd0 || newer_end == 64'd0) begin
        res.status = ST_NO_DIR;
      end else if (!((d1_pos && d2_pos) || (d1_neg && d2_neg))) begin
        res.status = ST_NO_DIR;
      end else begin
        target = d2_pos ? fwd_target : bwd_target;
        if (target == 64'd0) begin
          res.status = ST_ZERO_TGT;
        end else if (target == issued_tgt) begin
          res.status = ST_DUPLICATE;
        end else begin
          res.status       = ST_ISSUED;
          res.issue        = 1'b1;
          res.target_space = space_tag;
          res.target_addr  = target;
        end
      end
    end
  end

  // Shift history and remember the issued target
  always_ff @(posedge clk) begin
    if (rst) begin
      older_end  <= '0;
      newer_end  <= '0;
      issued_tgt <= '0;
      d1_pos     <= 1'b0;
      d1_neg     <= 1'b0;
    end else if (adv) begin
      if (shift) begin
        older_end <= newer_end;
        newer_end <= blk_end;
        d1_pos    <= d2_pos;
        d1_neg    <= d2_neg;
      end
      if (res.issue) begin
        issued_tgt <= target;
      end
    end
  end

`ifndef SYNTHESIS
  a_last_target_follows_issue: assert property (@(posedge clk) disable iff (rst)
    adv && res.issue |=> issued_tgt == $past(res.target_addr))
    else $error("last issued target not updated");

  a_dup_keeps_last: assert property (@(posedge clk) disable iff (rst)
    adv && res.status == ST_DUPLICATE |=> $stable(issued_tgt))
    else $error("duplicate changed last issued target");

  a_shift_distinct: assert property (@(posedge clk) disable iff (rst)
    adv && shift |=> older_end != newer_end)
    else $error("history holds the same block twice");

  a_issue_nonzero: assert property (@(posedge clk) disable iff (rst)
    res.issue |-> res.target_addr != 64'd0 && res.target_space != 64'd0)
    else $error("issued request without target or space");
`endif

endmodule

@@ rtl/core/phase_aware_block_prefetch_policy.sv @@
// ----------------------------------------------------------------------------
// phase_aware_block_prefetch_policy
// Picks a page prefetch region for each fault hint and issues cross-block
// prefetch requests from the recent block-end history.
// ----------------------------------------------------------------------------
// Accepts one fault hint per clock while not stalled and returns one result
// per hint, in order. A hint is captured in an input register, decided by
// compare and select logic, and shown from a result register once that
// register is free; the block keeps taking hints while a result waits, and
// stalls only when both registers are full. The history loop (last two block
// ends and the last issued target) closes inside the decision cycle, so each
// hint sees the state left by the one before it. Configuration must be
// written through cfg_we/cfg_index/cfg_wdata only while no hint is in
// flight; the block itself does not enforce this.
module phase_aware_block_prefetch_policy import pabpp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  pabpp_hint_if.sink hint,
  pabpp_result_if.source result,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_wdata
);

  cfg_t        cfg;
  region_t     region;
  xb_result_t  xb;

  // Input stage
  logic        s1_valid;
  logic [8:0]  s1_page;
  logic [8:0]  s1_lo;
  logic [9:0]  s1_hi;
  logic [63:0] s1_bend;
  logic [63:0] s1_space;
  logic [63:0] s1_fwd;
  logic [63:0] s1_bwd;

  // Result stage
  logic        res_valid;
  region_t     res_region;
  xb_result_t  res_xb;

  logic        out_free;
  logic        s1_adv;
  logic        in_take;

  assign out_free   = !res_valid || result.ready;
  assign s1_adv     = s1_valid && out_free;
  assign hint.ready = !s1_valid || out_free;
  assign in_take    = hint.valid && hint.ready;

  pabpp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Capture the request, with both candidate targets worked out ahead
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (hint.ready) begin
      s1_valid <= hint.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_page  <= hint.fault_page;
      s1_lo    <= hint.region_lo;
      s1_hi    <= hint.region_hi;
      s1_bend  <= hint.blk_end;
      s1_space <= hint.space_tag;
      s1_fwd   <= hint.blk_end + 64'd1;
      s1_bwd   <= hint.blk_end - BLOCK_BYTES;
    end
  end

  pabpp_region u_region (
    .cfg        (cfg),
    .fault_page (s1_page),
    .region_lo  (s1_lo),
    .region_hi  (s1_hi),
    .region     (region)
  );

  pabpp_xblock u_xblock (
    .clk        (clk),
    .rst        (rst),
    .adv        (s1_adv),
    .cfg        (cfg),
    .blk_end    (s1_bend),
    .space_tag  (s1_space),
    .fwd_target (s1_fwd),
    .bwd_target (s1_bwd),
    .res        (xb)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_region <= region;
      res_xb     <= xb;
    end
  end

  assign result.valid        = res_valid;
  assign result.handled      = res_region.handled;
  assign result.region_valid = res_region.region_valid;
  assign result.result_lo    = res_region.result_lo;
  assign result.result_hi    = res_region.result_hi;
  assign result.status       = res_xb.status;
  assign result.issue        = res_xb.issue;
  assign result.target_space = res_xb.target_space;
  assign result.target_addr  = res_xb.target_addr;

endmodule
